// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Field widths, command codes and the link record passed along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 4;
  localparam int COUNT_W      = 5;
  localparam int CAPACITY_DEF = 16;

  // Command codes of the input beat
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } spq_cmd_t;

  // What one cell shows its right-hand neighbour (and the read mux)
  typedef struct packed {
    logic              valid;  // cell holds an entry
    logic              keep;   // entry stays ahead of the new one
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] prio;
  } spq_link_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry, decides whether it stays ahead of an incoming entry, and on
// an insert either keeps its entry, takes the new one or takes its left
// neighbour's entry (shift back by one).
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              shift_en,
  input  wire logic [DATA_W-1:0] new_data,
  input  wire logic [DATA_W-1:0] new_prio,
  input  wire spq_link_t         link_in,
  output spq_link_t              link_out
);

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [DATA_W-1:0] prio_r, prio_nxt;
  logic              ahead;

  // Stored entry stays ahead: lower priority, or equal priority with data >= new
  always_comb begin
    ahead = ($signed(prio_r) < $signed(new_prio)) ||
            ((prio_r == new_prio) && !($signed(data_r) < $signed(new_data)));
  end

  assign link_out.valid = valid_r;
  assign link_out.keep  = valid_r & ahead;
  assign link_out.data  = data_r;
  assign link_out.prio  = prio_r;

  // Keep, take new entry, or take the left neighbour's entry
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    prio_nxt  = prio_r;
    if (shift_en && !link_out.keep) begin
      if (link_in.keep) begin
        valid_nxt = 1'b1;
        data_nxt  = new_data;
        prio_nxt  = new_prio;
      end else begin
        valid_nxt = link_in.valid;
        data_nxt  = link_in.data;
        prio_nxt  = link_in.prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue_insert.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_insert: bounded sorted priority queue
// A row of CAPACITY compare-and-shift cells kept in ascending priority order.
// ----------------------------------------------------------------------------
// A beat accepted on start gives its result on the out_ ports with out_valid
// high in the very next cycle, and busy never rises, so a command may be
// issued in every cycle. An insert needs no sequencing: every cell compares
// its entry with the new one in parallel and shifts towards the tail at the
// same edge; a read picks one of the first min(CAPACITY, 16) cells through a
// mux. Results are shown for a single cycle and the receiver cannot stall
// them. An insert into a full queue is dropped and flagged on
// out_insert_refused.
`default_nettype none

module sorted_priority_queue_insert
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_cmd,
  input  wire logic [DATA_W-1:0] in_data_value,
  input  wire logic [DATA_W-1:0] in_prio,
  input  wire logic [POS_W-1:0]  in_position,
  output logic                   out_valid,
  output logic [DATA_W-1:0]      out_read_data,
  output logic [DATA_W-1:0]      out_read_prio,
  output logic                   out_read_valid,
  output logic [COUNT_W-1:0]     out_entry_count,
  output logic                   out_insert_refused
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  spq_link_t        links [CAPACITY+1];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept, is_insert, full, shift_en;
  spq_link_t        rd_sel;

  logic                 out_valid_r;
  logic [DATA_W-1:0]    rd_data_r, rd_prio_r;
  logic                 rd_valid_r, refused_r;
  logic [COUNT_W-1:0]   count_out_r;

  // Commands never stall
  assign busy      = 1'b0;
  assign accept    = start & ~busy;
  assign is_insert = (spq_cmd_t'(in_cmd) == CMD_INSERT);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign shift_en  = accept & is_insert & ~full;

  // Head of the row: the new entry always enters behind a virtual kept entry
  assign links[0].valid = 1'b1;
  assign links[0].keep  = 1'b1;
  assign links[0].data  = '0;
  assign links[0].prio  = '0;

  // Cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    spq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .new_data (in_data_value),
      .new_prio (in_prio),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  // Entry count
  always_comb begin
    count_nxt = count_r;
    if (shift_en) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // Read mux over the positions reachable by in_position
  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (in_position == POS_W'(k)) begin
        rd_sel = links[k+1];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Result beat registers
  always_ff @(posedge clk) begin
    if (accept) begin
      count_out_r <= COUNT_W'(count_nxt);
      if (is_insert) begin
        rd_data_r  <= '0;
        rd_prio_r  <= '0;
        rd_valid_r <= 1'b0;
        refused_r  <= full;
      end else begin
        rd_valid_r <= rd_sel.valid;
        rd_data_r  <= rd_sel.valid ? rd_sel.data : '0;
        rd_prio_r  <= rd_sel.valid ? rd_sel.prio : '0;
        refused_r  <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = rd_data_r;
  assign out_read_prio      = rd_prio_r;
  assign out_read_valid     = rd_valid_r;
  assign out_entry_count    = count_out_r;
  assign out_insert_refused = refused_r;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for sorted_priority_queue_insert
// Drives insert and read beats through the start/busy handshake. A shadow
// sorted array predicts every result beat, and each result beat is checked
// field by field in order of issue.
// ----------------------------------------------------------------------------

module testbench;

  import spq_pkg::*;

  localparam int QUEUE_DEPTH = CAPACITY_DEF;

  // One command beat as the sender presents it
  typedef struct {
    spq_cmd_t          cmd;
    logic [DATA_W-1:0] data_value;
    logic [DATA_W-1:0] prio;
    logic [POS_W-1:0]  position;
  } queue_cmd_t;

  // One result beat as the block shows it
  typedef struct {
    logic [DATA_W-1:0]  read_data;
    logic [DATA_W-1:0]  read_prio;
    logic               read_valid;
    logic [COUNT_W-1:0] entry_count;
    logic               insert_refused;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic [DATA_W-1:0] in_data_value = '0;
  logic [DATA_W-1:0] in_prio = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic [DATA_W-1:0] out_read_data;
  logic [DATA_W-1:0] out_read_prio;
  logic out_read_valid;
  logic [COUNT_W-1:0] out_entry_count;
  logic out_insert_refused;

  // Stimulus and expectation stores
  queue_cmd_t    beats_to_send[$];
  queue_result_t expected_results[$];
  int beats_issued = 0;
  int beats_accepted = 0;
  int sender_idle_pct = 0;
  logic beat_taken = 1'b0;
  int mismatches = 0;

  // Shadow copy of the queue contents
  logic signed [DATA_W-1:0] shadow_data[QUEUE_DEPTH];
  logic signed [DATA_W-1:0] shadow_prio[QUEUE_DEPTH];
  int shadow_count = 0;

  // What the run reached
  int inserts_stored = 0;
  int inserts_refused = 0;
  int reads_hit = 0;
  int reads_missed = 0;

  sorted_priority_queue_insert #(
    .CAPACITY(QUEUE_DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_data_value(in_data_value),
    .in_prio(in_prio),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_read_data(out_read_data),
    .out_read_prio(out_read_prio),
    .out_read_valid(out_read_valid),
    .out_entry_count(out_entry_count),
    .out_insert_refused(out_insert_refused)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted beat to the shadow queue and return its result
  function automatic queue_result_t apply_to_shadow_queue(input queue_cmd_t beat);
    queue_result_t res;
    logic signed [DATA_W-1:0] new_data;
    logic signed [DATA_W-1:0] new_prio;
    int slot;
    res = '{read_data: '0, read_prio: '0, read_valid: 1'b0,
            entry_count: '0, insert_refused: 1'b0};
    new_data = beat.data_value;
    new_prio = beat.prio;
    if (beat.cmd == CMD_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.insert_refused = 1'b1;
        inserts_refused++;
      end else begin
        // skip lower priorities, and equal ones whose data is at least as large
        slot = 0;
        while (slot < shadow_count &&
               (shadow_prio[slot] < new_prio ||
                (shadow_prio[slot] == new_prio && shadow_data[slot] >= new_data)))
          slot++;
        for (int i = shadow_count; i > slot; i--) begin
          shadow_data[i] = shadow_data[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_data[slot] = new_data;
        shadow_prio[slot] = new_prio;
        shadow_count++;
        inserts_stored++;
      end
    end else begin
      if (int'(beat.position) < shadow_count) begin
        res.read_data  = shadow_data[beat.position];
        res.read_prio  = shadow_prio[beat.position];
        res.read_valid = 1'b1;
        reads_hit++;
      end else begin
        reads_missed++;
      end
    end
    res.entry_count = shadow_count[COUNT_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  // Word picker biased towards extremes and small values to force ties
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return 32'hffff_ffff;
      4:       return DATA_W'($urandom_range(4)) - DATA_W'(2);
      default: return $urandom;
    endcase
  endfunction

  function automatic queue_cmd_t make_random_beat();
    queue_cmd_t beat;
    beat.cmd        = ($urandom_range(1) == 0) ? CMD_INSERT : CMD_READ;
    beat.data_value = pick_word();
    beat.prio       = pick_word();
    beat.position   = POS_W'($urandom_range(15));
    return beat;
  endfunction

  task automatic queue_beat(input spq_cmd_t cmd, input logic [DATA_W-1:0] data_value,
                            input logic [DATA_W-1:0] prio, input logic [POS_W-1:0] position);
    queue_cmd_t beat;
    beat = '{cmd: cmd, data_value: data_value, prio: prio, position: position};
    beats_to_send.push_back(beat);
    beats_issued++;
  endtask

  // Hold off until every issued beat is taken and every result has come
  task automatic wait_drained();
    while (beats_accepted != beats_issued || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Driver: presents the next beat on the falling edge
  always @(negedge clk) begin : drive_beats
    queue_cmd_t next_beat;
    if (rst_n && (!start || beat_taken)) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_beat = beats_to_send.pop_front();
        start         <= 1'b1;
        in_cmd        <= next_beat.cmd;
        in_data_value <= next_beat.data_value;
        in_prio       <= next_beat.prio;
        in_position   <= next_beat.position;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks result beats, then records beats taken at this edge
  always @(posedge clk) begin : watch_results
    queue_result_t want;
    queue_cmd_t taken;
    beat_taken <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result beat, entry_count", '0,
                      DATA_W'(out_entry_count));
      end else begin
        want = expected_results.pop_front();
        if (out_read_data !== want.read_data)
          flag_mismatch("read_data", want.read_data, out_read_data);
        if (out_read_prio !== want.read_prio)
          flag_mismatch("read_prio", want.read_prio, out_read_prio);
        if (out_read_valid !== want.read_valid)
          flag_mismatch("read_valid", DATA_W'(want.read_valid), DATA_W'(out_read_valid));
        if (out_entry_count !== want.entry_count)
          flag_mismatch("entry_count", DATA_W'(want.entry_count),
                        DATA_W'(out_entry_count));
        if (out_insert_refused !== want.insert_refused)
          flag_mismatch("insert_refused", DATA_W'(want.insert_refused),
                        DATA_W'(out_insert_refused));
      end
    end
    if (rst_n && start && !busy) begin
      taken = '{cmd: spq_cmd_t'(in_cmd), data_value: in_data_value,
                prio: in_prio, position: in_position};
      expected_results.push_back(apply_to_shadow_queue(taken));
      beats_accepted++;
    end
  end

  // Stimulus sequence
  initial begin : run_regression
    int idle_plan[3];
    idle_plan = '{0, 82, 11};
    foreach (shadow_data[i]) begin
      shadow_data[i] = '0;
      shadow_prio[i] = '0;
    end
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    @(posedge clk);

    // Directed: reads on an empty queue, extreme values and ties
    sender_idle_pct = 0;
    queue_beat(CMD_READ,   32'h0000_0000, 32'h0000_0000, 4'd0);
    queue_beat(CMD_READ,   32'hffff_ffff, 32'hffff_ffff, 4'd15);
    queue_beat(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 4'd0);
    queue_beat(CMD_INSERT, 32'h7fff_ffff, 32'h0000_0000, 4'd0);  // larger data goes ahead
    queue_beat(CMD_INSERT, 32'h8000_0000, 32'h0000_0000, 4'd0);  // smaller data goes behind
    queue_beat(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 4'd0);  // exact tie lands after
    queue_beat(CMD_INSERT, 32'h0000_0005, 32'h8000_0000, 4'd0);  // lowest priority at head
    queue_beat(CMD_INSERT, 32'hffff_fffb, 32'h7fff_ffff, 4'd0);  // highest priority at tail
    queue_beat(CMD_INSERT, 32'h0000_0001, 32'hffff_ffff, 4'd0);
    queue_beat(CMD_INSERT, 32'h0000_0001, 32'h0000_0001, 4'd0);
    for (int p = 0; p < 8; p++)
      queue_beat(CMD_READ, 32'h0000_0000, 32'h0000_0000, POS_W'(p));
    queue_beat(CMD_READ, 32'h0000_0000, 32'h0000_0000, 4'd8);   // just past the count
    queue_beat(CMD_READ, 32'h0000_0000, 32'h0000_0000, 4'd15);
    wait_drained();

    // Random phases: filling up, then full-queue refusals and reads
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_plan[phase];
      repeat (660) begin
        beats_to_send.push_back(make_random_beat());
        beats_issued++;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      flag_mismatch("results left outstanding", '0, DATA_W'(expected_results.size()));

    $display("Covered %0d beats: %0d inserts stored, %0d refused on a full queue,",
             beats_accepted, inserts_stored, inserts_refused);
    $display("%0d reads of held entries and %0d reads past the count; %0d mismatches.",
             reads_hit, reads_missed, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d beats accepted of %0d, %0d results outstanding",
             beats_accepted, beats_issued, expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sorted_priority_queue_insert.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_insert.sv
test/testbench.sv
